// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define UUE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define UUE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/uue_pkg.sv -----
// Shared types, constants and functions of the uuencode stream block.
package uue_pkg;

    localparam int LINE_BYTES_DEF  = 45;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] CHAR_SPACE    = 7'd32;
    localparam logic [6:0] CHAR_BACKQUOTE = 7'd96;
    localparam logic [5:0] SIX_MASK      = 6'o77;

    typedef struct packed {
        logic       hdr;
        logic [5:0] hdr_val;
        logic       grp;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
    } t_work;

    function automatic logic [6:0] code_of(input logic [5:0] v);
        logic [5:0] m;
        m = v & SIX_MASK;
        code_of = (m == 6'd0) ? CHAR_BACKQUOTE : ({1'b0, m} + CHAR_SPACE);
    endfunction

endpackage

// ----- hw/rtl/uue_front.sv -----
// Front end: accepts bytes, tracks line and group state, emits work entries.
module uue_front #(
    parameter int LINE_BYTES = uue_pkg::LINE_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [31:0]    i_total_length,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_q_ready,
    output logic           o_push,
    output uue_pkg::t_work o_work
);

    logic [31:0] r_rem,   n_rem;
    logic [5:0]  r_llen,  n_llen;
    logic [5:0]  r_lpos,  n_lpos;
    logic [7:0]  r_g_hi,  n_g_hi;
    logic [7:0]  r_g_lo,  n_g_lo;
    logic [1:0]  r_gidx,  n_gidx;

    logic       accept;
    logic       active;
    logic       hdr;
    logic [5:0] line_len;
    logic [5:0] lpos_inc;
    logic       line_end;
    logic       flush;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_q_ready;
    assign accept      = i_valid && i_q_ready;
    assign active      = (r_rem != 32'd0);
    assign hdr         = (r_lpos == 6'd0);
    assign lpos_inc    = r_lpos + 6'd1;

    always_comb begin
        if (hdr) begin
            line_len = (r_rem < 32'(LINE_BYTES)) ? r_rem[5:0] : 6'(LINE_BYTES);
        end else begin
            line_len = r_llen;
        end
    end

    assign line_end = (lpos_inc == line_len);
    assign flush    = (r_gidx >= 2'd2) || line_end;

    always_comb begin
        n_rem  = r_rem;
        n_llen = r_llen;
        n_lpos = r_lpos;
        n_g_hi = r_g_hi;
        n_g_lo = r_g_lo;
        n_gidx = r_gidx;
        o_push = 1'b0;
        o_work.hdr     = hdr;
        o_work.hdr_val = line_len;
        o_work.grp     = flush;
        o_work.c1      = r_g_hi;
        o_work.c2      = r_g_lo;
        o_work.c3      = i_data_byte;
        unique case (r_gidx)
            2'd0: begin
                o_work.c1 = i_data_byte;
                o_work.c2 = 8'd0;
                o_work.c3 = 8'd0;
            end
            2'd1: begin
                o_work.c2 = i_data_byte;
                o_work.c3 = 8'd0;
            end
            default: begin
            end
        endcase
        if (accept && active) begin
            n_rem  = r_rem - 32'd1;
            n_llen = line_len;
            o_push = hdr || flush;
            if (flush) begin
                n_gidx = 2'd0;
                n_lpos = line_end ? 6'd0 : lpos_inc;
            end else begin
                n_lpos = lpos_inc;
                n_gidx = r_gidx + 2'd1;
                if (r_gidx == 2'd0) begin
                    n_g_hi = i_data_byte;
                end else begin
                    n_g_lo = i_data_byte;
                end
            end
        end
        if (i_cfg_valid) begin
            n_rem  = i_total_length;
            n_llen = 6'd0;
            n_lpos = 6'd0;
            n_gidx = 2'd0;
            n_g_hi = 8'd0;
            n_g_lo = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_hi <= n_g_hi;
        r_g_lo <= n_g_lo;
        if (!i_rst_n) begin
            r_rem  <= 32'd1;
            r_llen <= 6'd0;
            r_lpos <= 6'd0;
            r_gidx <= 2'd0;
        end else begin
            r_rem  <= n_rem;
            r_llen <= n_llen;
            r_lpos <= n_lpos;
            r_gidx <= n_gidx;
        end
    end

endmodule

// ----- hw/rtl/uue_queue.sv -----
// Work queue between the front end and the character emitter.
module uue_queue #(
    parameter int DEPTH = uue_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uue_pkg::t_work i_work,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output uue_pkg::t_work o_work
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    uue_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, n_wptr;
    logic [AW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_cnt,  n_cnt;
    logic           push;
    logic           pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != CW'(0));
    assign o_work  = r_mem[r_rptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? AW'(0) : r_wptr + AW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? AW'(0) : r_rptr + AW'(1);
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_work;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/uue_back.sv -----
// Back end: turns work entries into registered characters, one per unstalled cycle.
module uue_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  uue_pkg::t_work i_work,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [6:0]     o_code_char,
    output logic           o_run_last
);

    logic [2:0] r_step;
    logic       r_valid;
    logic [6:0] r_code;
    logic       r_last;

    logic       load;
    logic       is_hdr;
    logic [1:0] csel;
    logic [5:0] val;
    logic       last;

    assign load   = i_q_valid && (!r_valid || i_ready);
    assign is_hdr = i_work.hdr && (r_step == 3'd0);
    assign csel   = 2'(r_step - {2'b00, i_work.hdr});

    always_comb begin
        case (csel)
            2'd0:    val = i_work.c1[7:2];
            2'd1:    val = {i_work.c1[1:0], i_work.c2[7:4]};
            2'd2:    val = {i_work.c2[3:0], i_work.c3[7:6]};
            default: val = i_work.c3[5:0];
        endcase
        if (is_hdr) begin
            val  = i_work.hdr_val;
            last = !i_work.grp;
        end else begin
            last = (csel == 2'd3);
        end
    end

    assign o_pop       = load && last;
    assign o_valid     = r_valid;
    assign o_code_char = r_code;
    assign o_run_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code <= uue_pkg::code_of(val);
            r_last <= last;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_step  <= last ? 3'd0 : r_step + 3'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ----- hw/rtl/uuencode_stream.sv -----
// Top level of the streaming uuencoder.
// Streaming uuencoder: one raw byte in per transfer, printable characters out, one per
// transfer, with o_run_last marking the last character a byte causes. Writing
// i_total_length starts a new message (reset leaves a length of one); bytes past the
// message end are taken and dropped. A byte that opens a line costs one header character,
// a byte that closes a group or a line costs four; the output register emits one
// character per cycle while work is queued and the receiver is ready, so a full line
// of LINE_BYTES bytes gives 1 + 4 * ceil(LINE_BYTES/3) characters (61 for 45 bytes), and
// a single byte gives up to 5. The input side takes a byte every cycle while the
// QUEUE_DEPTH-entry work queue has room.
module uuencode_stream #(
    parameter int LINE_BYTES  = uue_pkg::LINE_BYTES_DEF,
    parameter int QUEUE_DEPTH = uue_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_total_length,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_code_char,
    output logic        o_run_last
);

    uue_pkg::t_work push_work;
    uue_pkg::t_work head_work;
    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;

    uue_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_total_length (i_total_length),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_q_ready      (q_ready),
        .o_push         (push),
        .o_work         (push_work)
    );

    uue_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (head_work)
    );

    uue_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_work      (head_work),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_char (o_code_char),
        .o_run_last  (o_run_last)
    );

endmodule

// ----- hw/rtl/uue_checker.sv -----
// Port-level checker for the streaming uuencoder, bound to the top level.
`include "assert_macros.svh"

module uue_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [6:0] o_code_char,
    input logic       o_run_last
);

    `UUE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_code_char) && $stable(o_run_last), "output changed while stalled")
    `UUE_ASSERT(a_char_range, i_clk, i_rst_n, o_valid |-> (o_code_char >= 7'd32) && (o_code_char <= 7'd96), "character outside printable range")
    `UUE_ASSERT(a_run_continues, i_clk, i_rst_n, o_valid && i_ready && !o_run_last |=> o_valid, "gap inside a character run")
    `UUE_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

bind uuencode_stream uue_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_code_char (o_code_char),
    .o_run_last  (o_run_last)
);

// ----- bench/tb.sv -----
// Self-checking testbench for uuencode_stream: directed table, then random messages.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE        = uue_pkg::LINE_BYTES_DEF;
    localparam int ITEMS       = 210;
    localparam int SETTLE      = 32;
    localparam int HOLD_CYCLES = 200;
    localparam int STUCK_LIMIT = 2000;

    localparam logic [6:0] BQ   = uue_pkg::CHAR_BACKQUOTE;
    localparam logic [6:0] HDR1 = 7'd33;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_code;

    typedef enum logic {ST_BYTE, ST_LEN} t_step_kind;

    typedef struct packed {
        t_step_kind      kind;
        logic [31:0]     val;
        logic            typed;
        logic [2:0]      n;
        logic [0:4][6:0] chars;
    } t_step;

    localparam logic [0:4][6:0] NONE = '0;

    localparam t_step PLAN [26] = '{
        '{ST_BYTE, 32'h00, 1'b1, 3'd5, {HDR1, BQ, BQ, BQ, BQ}},
        '{ST_BYTE, 32'hA5, 1'b1, 3'd0, NONE},
        '{ST_LEN,  32'h0,  1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hFF, 1'b1, 3'd0, NONE},
        '{ST_BYTE, 32'h12, 1'b1, 3'd0, NONE},
        '{ST_LEN,  32'h1,  1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hFF, 1'b1, 3'd5, {HDR1, 7'd95, 7'd80, BQ, BQ}},
        '{ST_LEN,  32'h3,  1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h00, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hFF, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h55, 1'b0, 3'd0, NONE},
        '{ST_LEN,  32'h2,  1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hC3, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h3C, 1'b0, 3'd0, NONE},
        '{ST_LEN,  32'h4,  1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h80, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h01, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h7E, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hFE, 1'b0, 3'd0, NONE},
        '{ST_LEN,  32'hFFFF_FFFF, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h00, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hFF, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hAA, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h55, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'h0F, 1'b0, 3'd0, NONE},
        '{ST_BYTE, 32'hF0, 1'b0, 3'd0, NONE}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_total_length = 32'd0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte    = 8'd0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [6:0]  o_code_char;
    logic        o_run_last;

    uuencode_stream dut (.*);

    always #2 i_clk = ~i_clk;

    // encoder model state
    logic [31:0] left     = 32'd1;
    logic [5:0]  ln_len   = '0;
    logic [5:0]  ln_pos   = '0;
    logic [7:0]  held_hi  = '0;
    logic [7:0]  held_lo  = '0;
    logic [1:0]  held_cnt = '0;

    t_code due_chars[$];

    int  errors     = 0;
    int  chars_seen = 0;
    int  msg_bytes  = 0;
    int  ignored    = 0;
    int  settings   = 0;
    int  stuck      = 0;
    bit  quiet      = 1'b0;
    bit  hold_out   = 1'b0;

    function automatic logic [6:0] six_to_char(input logic [5:0] v);
        return (v == 6'd0) ? BQ : ({1'b0, v} + uue_pkg::CHAR_SPACE);
    endfunction

    function automatic void encode_byte(input logic [7:0] b, output t_code res [5],
                                        output int n);
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       flush;
        n = 0;
        if (left == 32'd0)
            return;
        if (ln_pos == 6'd0) begin
            ln_len = (left < LINE) ? left[5:0] : 6'(LINE);
            res[n] = '{ch: six_to_char(ln_len), last: 1'b0};
            n++;
        end
        ln_pos = ln_pos + 6'd1;
        left   = left - 32'd1;
        flush  = (held_cnt >= 2'd2) || (ln_pos == ln_len);
        if (!flush) begin
            if (held_cnt == 2'd0)
                held_hi = b;
            else
                held_lo = b;
            held_cnt = held_cnt + 2'd1;
        end else begin
            c1 = b;
            c2 = 8'd0;
            c3 = 8'd0;
            if (held_cnt == 2'd1) begin
                c1 = held_hi;
                c2 = b;
            end else if (held_cnt == 2'd2) begin
                c1 = held_hi;
                c2 = held_lo;
                c3 = b;
            end
            res[n]     = '{ch: six_to_char(c1[7:2]), last: 1'b0};
            res[n + 1] = '{ch: six_to_char({c1[1:0], c2[7:4]}), last: 1'b0};
            res[n + 2] = '{ch: six_to_char({c2[3:0], c3[7:6]}), last: 1'b0};
            res[n + 3] = '{ch: six_to_char(c3[5:0]), last: 1'b0};
            n += 4;
            held_cnt = 2'd0;
            held_hi  = 8'd0;
            held_lo  = 8'd0;
            if (ln_pos == ln_len)
                ln_pos = 6'd0;
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [31:0] len);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_total_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        left     = len;
        ln_len   = '0;
        ln_pos   = '0;
        held_hi  = '0;
        held_lo  = '0;
        held_cnt = '0;
        settings++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] n_typed,
                             input logic [0:4][6:0] typed_chars);
        t_code res [5];
        int    n;
        while (!quiet && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        if (left != 32'd0)
            msg_bytes++;
        else
            ignored++;
        encode_byte(b, res, n);
        if (typed) begin
            for (int k = 0; k < n_typed; k++)
                due_chars.push_back('{ch: typed_chars[k], last: (k == n_typed - 1)});
        end else begin
            for (int k = 0; k < n; k++)
                due_chars.push_back(res[k]);
        end
    endtask

    // receiver: random back-pressure, one long hold on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                hold_out = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= quiet || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge i_clk) begin : mon
        t_code due;
        if (i_rst_n && o_valid && i_ready) begin
            chars_seen++;
            if (due_chars.size() == 0) begin
                $error("unexpected transfer: code_char %0d run_last %0b",
                       o_code_char, o_run_last);
                errors++;
            end else begin
                due = due_chars.pop_front();
                if (o_code_char !== due.ch) begin
                    $error("code_char: expected %0d, got %0d", due.ch, o_code_char);
                    errors++;
                end
                if (o_run_last !== due.last) begin
                    $error("run_last: expected %0b, got %0b", due.last, o_run_last);
                    errors++;
                end
            end
        end
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("uuencode_stream test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] len;
        int          count;
        int          phase;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[r]) begin
            if (PLAN[r].kind == ST_LEN)
                set_length(PLAN[r].val);
            else
                send_byte(PLAN[r].val[7:0], PLAN[r].typed, PLAN[r].n, PLAN[r].chars);
        end

        phase = 0;
        while (msg_bytes < ITEMS) begin
            case (phase)
                0: len = 32'd90;
                1: len = 32'd40;
                2: len = 32'd64;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       len = 32'd0;
                        1:       len = 32'hFFFF_FFFF;
                        2, 3:    len = $urandom_range(44, 92);
                        default: len = $urandom_range(1, 20);
                    endcase
                end
            endcase
            set_length(len);
            quiet = (phase == 2);
            if (phase == 0)
                hold_out = 1'b1;
            count = (len == 32'hFFFF_FFFF) ? $urandom_range(1, 60)
                                           : int'(len) + $urandom_range(0, 2);
            for (int j = 0; j < count; j++) begin
                if (phase == 1 && j == 20)
                    drain();
                send_byte(8'($urandom_range(0, 255)), 1'b0, 3'd0, NONE);
            end
            quiet = 1'b0;
            phase++;
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d message bytes and %0d bytes past the end, %0d characters checked",
                 msg_bytes, ignored, chars_seen);
        $display("%0d length settings incl. 0, 1 and all ones, long output hold, mid-message drain",
                 settings);
        if (errors == 0 && due_chars.size() == 0)
            $display("uuencode_stream test passed");
        else
            $display("uuencode_stream test failed");
        $finish;
    end

endmodule

// ----- uuencode_stream.f -----
+incdir+hw/rtl
hw/rtl/uue_pkg.sv
hw/rtl/uue_front.sv
hw/rtl/uue_queue.sv
hw/rtl/uue_back.sv
hw/rtl/uuencode_stream.sv
hw/rtl/uue_checker.sv
bench/tb.sv
